[rtl/tgc_pkg.sv]
`timescale 1ns / 1ps

package tgc_pkg;

  localparam int TIME_W     = 32;
  localparam int PRESS_W    = 12;
  localparam int HOLD_T_W   = 16;
  localparam int THR_W      = 12;
  localparam int EVT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RADIUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_DISTANCE = 2'd2;

  localparam logic [HOLD_T_W-1:0] HOLD_TIME_RST      = 16'd500;
  localparam logic [THR_W-1:0]    HOLD_RADIUS_RST    = 12'd20;
  localparam logic [THR_W-1:0]    SWIPE_DISTANCE_RST = 12'd60;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE        = 3'd0,
    EVT_PRESS       = 3'd1,
    EVT_RELEASE     = 3'd2,
    EVT_HOLD        = 3'd3,
    EVT_SWIPE_LEFT  = 3'd4,
    EVT_SWIPE_RIGHT = 3'd5,
    EVT_SWIPE_UP    = 3'd6,
    EVT_SWIPE_DOWN  = 3'd7
  } event_t;

endpackage

[rtl/tgc_in_if.sv]
`timescale 1ns / 1ps

interface tgc_in_if #(
  parameter int COORD_BITS = 12
);
  import tgc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] sample_x;
  logic [COORD_BITS-1:0] sample_y;
  logic [PRESS_W-1:0]    pressure;
  logic [TIME_W-1:0]     time_ms;

  modport source (output valid, output sample_x, output sample_y, output pressure,
                  output time_ms, input ready);
  modport sink   (input valid, input sample_x, input sample_y, input pressure,
                  input time_ms, output ready);
endinterface

[rtl/tgc_out_if.sv]
`timescale 1ns / 1ps

interface tgc_out_if;
  import tgc_pkg::*;

  logic             valid;
  logic             ready;
  logic [EVT_W-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

[rtl/touch_gesture_classifier.sv]
// Touch gesture classifier: one event code per touch sample.
// Pipeline: input register, then result register; an accepted sample moves from the input
// register into the result register once that one is empty or being drained.
// Throughput: one item per cycle; the result register stalls only on out_ch.ready low,
// and the input register still takes one further item while a result waits.
// Reset (rst_n low, synchronous): pipeline emptied, released state, press start
// cleared, thresholds back to 500 ms hold time, 20 hold radius, 60 swipe distance.
`timescale 1ns / 1ps

module touch_gesture_classifier #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tgc_in_if.sink                            in_ch,
  tgc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tgc_pkg::*;

  // Offsets and thresholds are compared at the wider of the two widths.
  localparam int CMP_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;

  // Configuration registers
  logic [HOLD_T_W-1:0] hold_time_r;
  logic [THR_W-1:0]    hold_radius_r;
  logic [THR_W-1:0]    swipe_distance_r;

  // Input register stage
  logic                  s1_valid_r, s1_valid_nxt;
  logic [COORD_BITS-1:0] s1_x_r;
  logic [COORD_BITS-1:0] s1_y_r;
  logic                  s1_pressed_r;
  logic [TIME_W-1:0]     s1_time_r;

  // Press tracking state
  logic                  touching_r, touching_nxt;
  logic [TIME_W-1:0]     start_time_r;
  logic [COORD_BITS-1:0] start_x_r;
  logic [COORD_BITS-1:0] start_y_r;

  // Result register
  logic   out_valid_r, out_valid_nxt;
  event_t evt_r, evt_nxt;

  // Handshake: the result register moves when empty or drained; the input
  // register moves when empty or its item passes into the result register.
  logic adv_out;
  logic load_out;
  logic in_rdy;
  logic accept;

  assign adv_out  = !out_valid_r || out_ch.ready;
  assign load_out = s1_valid_r && adv_out;
  assign in_rdy   = !s1_valid_r || adv_out;
  assign accept   = in_ch.valid && in_rdy;

  assign in_ch.ready       = in_rdy;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = evt_r;

  assign s1_valid_nxt  = accept ? 1'b1 : (load_out ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);

  // Offsets of the release point from the press point, as magnitude and sign.
  logic                  dx_pos, dy_pos;
  logic [COORD_BITS-1:0] ax, ay;
  logic [CMP_W-1:0]      ax_c, ay_c;
  logic [TIME_W-1:0]     duration;
  logic                  is_hold, is_swipe_h, is_swipe_v;
  event_t                release_evt;

  always_comb begin
    dx_pos   = s1_x_r > start_x_r;
    dy_pos   = s1_y_r > start_y_r;
    ax       = dx_pos ? (s1_x_r - start_x_r) : (start_x_r - s1_x_r);
    ay       = dy_pos ? (s1_y_r - start_y_r) : (start_y_r - s1_y_r);
    ax_c     = CMP_W'(ax);
    ay_c     = CMP_W'(ay);
    // Wraps modulo 2^32: a release stamped before its press reads as very long.
    duration = s1_time_r - start_time_r;

    is_hold    = (duration > TIME_W'(hold_time_r)) &&
                 (ax_c < CMP_W'(hold_radius_r)) && (ay_c < CMP_W'(hold_radius_r));
    is_swipe_h = (ax_c > CMP_W'(swipe_distance_r)) && (ax_c > ay_c);
    is_swipe_v = (ay_c > CMP_W'(swipe_distance_r)) && (ay_c > ax_c);

    // Priority: hold, then horizontal swipe, then vertical swipe.
    if (is_hold) begin
      release_evt = EVT_HOLD;
    end else if (is_swipe_h) begin
      release_evt = dx_pos ? EVT_SWIPE_RIGHT : EVT_SWIPE_LEFT;
    end else if (is_swipe_v) begin
      release_evt = dy_pos ? EVT_SWIPE_DOWN : EVT_SWIPE_UP;
    end else begin
      release_evt = EVT_RELEASE;
    end
  end

  // Event and next press state; held and idle samples give no event.
  always_comb begin
    touching_nxt = touching_r;
    evt_nxt      = EVT_NONE;
    if (s1_pressed_r && !touching_r) begin
      touching_nxt = 1'b1;
      evt_nxt      = EVT_PRESS;
    end else if (!s1_pressed_r && touching_r) begin
      touching_nxt = 1'b0;
      evt_nxt      = release_evt;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      touching_r       <= 1'b0;
      start_time_r     <= '0;
      start_x_r        <= '0;
      start_y_r        <= '0;
      hold_time_r      <= HOLD_TIME_RST;
      hold_radius_r    <= HOLD_RADIUS_RST;
      swipe_distance_r <= SWIPE_DISTANCE_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        touching_r <= touching_nxt;
        // Capture the press point on a press only.
        if (s1_pressed_r && !touching_r) begin
          start_time_r <= s1_time_r;
          start_x_r    <= s1_x_r;
          start_y_r    <= s1_y_r;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOLD_TIME:      hold_time_r      <= cfg_wdata;
          CFG_HOLD_RADIUS:    hold_radius_r    <= cfg_wdata[THR_W-1:0];
          CFG_SWIPE_DISTANCE: swipe_distance_r <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r       <= in_ch.sample_x;
      s1_y_r       <= in_ch.sample_y;
      s1_pressed_r <= |in_ch.pressure;
      s1_time_r    <= in_ch.time_ms;
    end
    if (load_out) begin
      evt_r <= evt_nxt;
    end
  end

endmodule

[rtl/tgc_checker.sv]
`timescale 1ns / 1ps

module tgc_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [tgc_pkg::EVT_W-1:0] event_code
);
  import tgc_pkg::*;

  logic out_acc;
  logic is_rel;
  logic down_r;

  assign out_acc = out_valid && out_ready;
  assign is_rel  = event_code inside {EVT_RELEASE, EVT_HOLD, EVT_SWIPE_LEFT,
                                      EVT_SWIPE_RIGHT, EVT_SWIPE_UP, EVT_SWIPE_DOWN};

  // Track press/release as seen on the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r <= 1'b0;
    end else if (out_acc && event_code == EVT_PRESS) begin
      down_r <= 1'b1;
    end else if (out_acc && is_rel) begin
      down_r <= 1'b0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("stalled result changed");

  a_press_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && event_code == EVT_PRESS |-> !down_r)
    else $error("press without release in between");

  a_release_after_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && is_rel |-> down_r)
    else $error("release without a press");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_code (out_ch.event_code)
);
